// ===== src/quaternion_multiply_rotate_top_assert.svh =====
// Assertion helpers for the quaternion unit top level.
// Both sample on the rising clock edge and stay quiet while reset is low.
`ifndef QUATERNION_MULTIPLY_ROTATE_TOP_ASSERT_SVH
`define QUATERNION_MULTIPLY_ROTATE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QMR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define QMR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== src/qmr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qmr_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 28;

	// register stages in one Hamilton product unit
	localparam int PROD_STAGES = 5;

	// quaternion components
	localparam int NQ = 4;
	localparam int QW = 0;
	localparam int QX = 1;
	localparam int QY = 2;
	localparam int QZ = 3;

	typedef enum logic {
		CMD_MUL = 1'b0,
		CMD_ROT = 1'b1
	} cmd_t;

	typedef logic [1:0] qidx_t;

	// minus sign of term k in component c sits at bit {c, k}
	localparam logic [15:0] TERM_NEG = 16'h428E;

	// term k of component c multiplies left[k] by right[c ^ k]
	function automatic qidx_t right_sel(input qidx_t c, input qidx_t k);
		return c ^ k;
	endfunction

	// conjugating the right operand flips every term that uses its vector part
	function automatic logic term_neg(input qidx_t c, input qidx_t k, input logic conj_r);
		return TERM_NEG[{c, k}] ^ (conj_r && (right_sel(c, k) != 2'd0));
	endfunction

endpackage

`default_nettype wire

// ===== src/qmr_hprod.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qmr_hprod
	import qmr_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic [PROD_STAGES-1:0]       adv,
	input  logic                         conj_r,
	input  logic signed [DATA_WIDTH-1:0] l [NQ],
	input  logic signed [DATA_WIDTH-1:0] r [NQ],
	output logic signed [DATA_WIDTH-1:0] p [NQ]
);

	localparam int LO_W = DATA_WIDTH / 2;
	localparam int HI_W = DATA_WIDTH - LO_W;
	localparam int PW   = 2 * DATA_WIDTH;
	localparam int SW   = PW + 2;
	localparam int RW   = SW - FRAC_BITS;

	localparam logic signed [SW-1:0] HALF =
		{{(SW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
	localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

	logic signed [DATA_WIDTH+LO_W:0]   pl_s1   [NQ][NQ];
	logic signed [DATA_WIDTH+HI_W-1:0] ph_s1   [NQ][NQ];
	logic signed [PW-1:0]              prod_s2 [NQ][NQ];
	logic signed [SW-1:0]              term    [NQ][NQ];
	logic signed [SW-1:0]              pair_s3 [NQ][2];
	logic signed [SW-1:0]              sum_s4  [NQ];
	logic signed [RW-1:0]              rnd     [NQ];
	logic                              fits    [NQ];
	logic signed [DATA_WIDTH-1:0]      p_s5    [NQ];

	// split the right operand: unsigned low half, signed high half
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int i = 0; i < NQ; i++) begin
				for (int j = 0; j < NQ; j++) begin
					pl_s1[i][j] <= l[i] * $signed({1'b0, r[j][LO_W-1:0]});
					ph_s1[i][j] <= l[i] * $signed(r[j][DATA_WIDTH-1:LO_W]);
				end
			end
		end
	end

	// merge the partial products into exact full products
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < NQ; i++) begin
				for (int j = 0; j < NQ; j++) begin
					prod_s2[i][j] <= (PW'(ph_s1[i][j]) <<< LO_W) + PW'(pl_s1[i][j]);
				end
			end
		end
	end

	// apply term signs; negate in the wide domain so no value overflows
	always_comb begin
		for (int c = 0; c < NQ; c++) begin
			for (int k = 0; k < NQ; k++) begin
				term[c][k] = term_neg(qidx_t'(c), qidx_t'(k), conj_r)
					? -SW'(prod_s2[k][right_sel(qidx_t'(c), qidx_t'(k))])
					:  SW'(prod_s2[k][right_sel(qidx_t'(c), qidx_t'(k))]);
			end
		end
	end

	// pair sums, rounding half folded into the first pair
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int c = 0; c < NQ; c++) begin
				pair_s3[c][0] <= term[c][0] + term[c][1] + HALF;
				pair_s3[c][1] <= term[c][2] + term[c][3];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int c = 0; c < NQ; c++) begin
				sum_s4[c] <= pair_s3[c][0] + pair_s3[c][1];
			end
		end
	end

	// drop the fraction bits, then clamp to the output range
	always_comb begin
		for (int c = 0; c < NQ; c++) begin
			rnd[c]  = sum_s4[c][SW-1:FRAC_BITS];
			fits[c] = (&rnd[c][RW-1:DATA_WIDTH-1]) || !(|rnd[c][RW-1:DATA_WIDTH-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int c = 0; c < NQ; c++) begin
				if (fits[c]) begin
					p_s5[c] <= rnd[c][DATA_WIDTH-1:0];
				end else begin
					p_s5[c] <= rnd[c][RW-1] ? SAT_MIN : SAT_MAX;
				end
			end
		end
	end

	assign p = p_s5;

endmodule

`default_nettype wire

// ===== src/quaternion_multiply_rotate_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_multiply_rotate_top_assert.svh"

// Quaternion multiply and rotate unit, signed fixed point (Q3.28 by default:
// DATA_WIDTH bits with FRAC_BITS fraction bits; FRAC_BITS must stay at most
// DATA_WIDTH - 2 so that 1.0 is representable). cmd = 0 returns the Hamilton
// product a*b; cmd = 1 rotates the vector (b_x, b_y, b_z) by a as (a*v)*conj(a),
// with b_w ignored and r_w returned as zero. Each product component is the
// exact sum of four full products, rounded to nearest (ties toward plus
// infinity) and saturated; in a rotation the intermediate a*v is rounded and
// saturated before the second product. Throughput is one word per clock
// while out_ready is high. An accepted word moves through the stages in order,
// raises out_valid in the last stage and leaves once out_ready is high. The
// path is two product units of five register stages each (partial multiply,
// product merge, pair sum, final sum, round and saturate). A multiply goes
// through the second unit too, multiplied by 1.0, so every word takes the same
// path. Each stage holds its own valid bit and loads whenever it is empty or
// the stage after it moves, so bubbles close up during an output stall and
// in_ready drops only when all ten stages hold a word.

module quaternion_multiply_rotate_top
	import qmr_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic signed [DATA_WIDTH-1:0] a_w,
	input  logic signed [DATA_WIDTH-1:0] a_x,
	input  logic signed [DATA_WIDTH-1:0] a_y,
	input  logic signed [DATA_WIDTH-1:0] a_z,
	input  logic signed [DATA_WIDTH-1:0] b_w,
	input  logic signed [DATA_WIDTH-1:0] b_x,
	input  logic signed [DATA_WIDTH-1:0] b_y,
	input  logic signed [DATA_WIDTH-1:0] b_z,

	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] r_w,
	output logic signed [DATA_WIDTH-1:0] r_x,
	output logic signed [DATA_WIDTH-1:0] r_y,
	output logic signed [DATA_WIDTH-1:0] r_z
);

	localparam int NS = 2 * PROD_STAGES;

	// fixed-point 1.0
	localparam logic signed [DATA_WIDTH-1:0] Q_ONE = DATA_WIDTH'(1) <<< FRAC_BITS;

	logic [NS:1]                  vld_s;
	logic [NS:1]                  adv;
	logic                         acc_in;
	logic                         acc_out;

	logic                         cmd_s [1:NS];
	logic signed [DATA_WIDTH-1:0] a_s   [1:PROD_STAGES][NQ];

	logic signed [DATA_WIDTH-1:0] a_in  [NQ];
	logic signed [DATA_WIDTH-1:0] b_in  [NQ];
	logic signed [DATA_WIDTH-1:0] p1    [NQ];
	logic signed [DATA_WIDTH-1:0] r2    [NQ];
	logic signed [DATA_WIDTH-1:0] p2    [NQ];

	// Stage enables: a stage advances when it is empty or its successor advances.
	always_comb begin
		adv[NS] = !vld_s[NS] || out_ready;
		for (int i = NS - 1; i >= 1; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_s[NS];
	assign acc_in    = in_valid && in_ready;
	assign acc_out   = out_valid && out_ready;

	// Valid bits travel alongside the data in both product units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int i = 2; i <= NS; i++) begin
				if (adv[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// Carry the command to the end, and a through the first unit for the
	// conjugate product.
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			cmd_s[1] <= cmd;
			a_s[1]   <= a_in;
		end
		for (int i = 2; i <= NS; i++) begin
			if (adv[i]) begin
				cmd_s[i] <= cmd_s[i-1];
			end
		end
		for (int i = 2; i <= PROD_STAGES; i++) begin
			if (adv[i]) begin
				a_s[i] <= a_s[i-1];
			end
		end
	end

	assign a_in[QW] = a_w;
	assign a_in[QX] = a_x;
	assign a_in[QY] = a_y;
	assign a_in[QZ] = a_z;

	// Rotation treats b as a pure vector: drop its scalar part.
	assign b_in[QW] = (cmd == CMD_ROT) ? '0 : b_w;
	assign b_in[QX] = b_x;
	assign b_in[QY] = b_y;
	assign b_in[QZ] = b_z;

	// First product: a*b, or a*v for a rotation.
	qmr_hprod #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_prod1 (
		.clk    (clk),
		.adv    (adv[PROD_STAGES:1]),
		.conj_r (1'b0),
		.l      (a_in),
		.r      (b_in),
		.p      (p1)
	);

	// Second product: conj(a) for a rotation, 1.0 for a plain multiply so the
	// first result passes through unchanged.
	assign r2[QW] = (cmd_s[PROD_STAGES] == CMD_ROT) ? a_s[PROD_STAGES][QW] : Q_ONE;
	assign r2[QX] = (cmd_s[PROD_STAGES] == CMD_ROT) ? a_s[PROD_STAGES][QX] : '0;
	assign r2[QY] = (cmd_s[PROD_STAGES] == CMD_ROT) ? a_s[PROD_STAGES][QY] : '0;
	assign r2[QZ] = (cmd_s[PROD_STAGES] == CMD_ROT) ? a_s[PROD_STAGES][QZ] : '0;

	qmr_hprod #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_prod2 (
		.clk    (clk),
		.adv    (adv[NS:PROD_STAGES+1]),
		.conj_r (1'b1),
		.l      (p1),
		.r      (r2),
		.p      (p2)
	);

	// Rotated vectors carry no scalar part.
	assign r_w = (cmd_s[NS] == CMD_ROT) ? '0 : p2[QW];
	assign r_x = p2[QX];
	assign r_y = p2[QY];
	assign r_z = p2[QZ];

	// Input back-pressure only when every stage holds a word.
	`QMR_ASSERT_NOW(a_full_stall, !in_ready, &vld_s)
	// A drained output keeps the whole pipeline moving.
	`QMR_ASSERT_NOW(a_drain_open, out_ready, in_ready)
	// Words in flight change only by accepted inputs and delivered results.
	`QMR_ASSERT_NEXT(a_occupancy, 1'b1, $countones(vld_s) == $past($countones(vld_s)) + $past(acc_in) - $past(acc_out))

endmodule

`default_nettype wire
